// ===== sv/ugbb_pkg.sv =====
// ----------------------------------------------------------------------------
// ugbb_pkg
// Shared types and codes for the uniform grid box binner.
// ----------------------------------------------------------------------------
package ugbb_pkg;

    localparam int COORD_W = 16;
    localparam int ID_W    = 16;
    // Cell index field width; covers grids of up to 256 columns or rows.
    localparam int IDX_W   = 8;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OFF_GRID = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [0:0] {
        CFG_ORIGIN_X = 1'b0,
        CFG_ORIGIN_Y = 1'b1
    } t_cfg_reg;

    localparam logic signed [COORD_W-1:0] ORIGIN_RESET = -16'sd512;

    typedef enum logic [1:0] {
        JOB_STATUS = 2'd0,
        JOB_ADD    = 2'd1,
        JOB_CLEAR  = 2'd2,
        JOB_READ   = 2'd3
    } t_job_kind;

    // Work handed from the classifier to the grid engine. A read uses x0/y0
    // as the cell column and row.
    typedef struct packed {
        t_job_kind         kind;
        logic [1:0]        status;
        logic [IDX_W-1:0]  x0;
        logic [IDX_W-1:0]  y0;
        logic [IDX_W-1:0]  x1;
        logic [IDX_W-1:0]  y1;
        logic [ID_W-1:0]   id;
    } t_job;

endpackage

// ===== sv/ugbb_ram.sv =====
// ----------------------------------------------------------------------------
// ugbb_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ugbb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ugbb_fifo.sv =====
// ----------------------------------------------------------------------------
// ugbb_fifo
// Short job queue between the classifier and the grid engine.
// ----------------------------------------------------------------------------
module ugbb_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ugbb_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output ugbb_pkg::t_job o_job,
    output logic          o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ugbb_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/ugbb_front.sv =====
// ----------------------------------------------------------------------------
// ugbb_front
// Takes commands, maps box corners to cells and classifies each command
// into a job for the grid engine.
// ----------------------------------------------------------------------------
module ugbb_front #(
    parameter int GRID_COLS = 32,
    parameter int GRID_ROWS = 32,
    parameter int CELL_SIZE = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic signed [15:0]   i_origin_x,
    input  logic signed [15:0]   i_origin_y,
    input  logic                 i_init_done,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_cmd,
    input  logic signed [15:0]   i_box_min_x,
    input  logic signed [15:0]   i_box_min_y,
    input  logic signed [15:0]   i_box_max_x,
    input  logic signed [15:0]   i_box_max_y,
    input  logic [15:0]          i_entity_id,
    input  logic [4:0]           i_cell_col,
    input  logic [4:0]           i_cell_row,
    output logic                 o_push,
    output ugbb_pkg::t_job       o_job,
    input  logic                 i_full
);

    // Exact floor(n / CELL_SIZE) for any 16-bit n: n * M >> S.
    localparam int     DIV_L  = $clog2(CELL_SIZE);
    localparam int     DIV_S  = 16 + DIV_L;
    localparam longint DIV_MV = ((longint'(1) << DIV_S) + CELL_SIZE - 1) / CELL_SIZE;
    localparam logic [16:0] DIV_M = 17'(DIV_MV);

    localparam logic signed [16:0] COLS_S = 17'(GRID_COLS);
    localparam logic signed [16:0] ROWS_S = 17'(GRID_ROWS);
    localparam logic [2:0]         K_LAST = 3'd4;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_fstate;

    t_fstate             r_state;
    logic [2:0]          r_k;
    ugbb_pkg::t_cmd      r_cmd;
    logic signed [15:0]  r_coord [4];
    logic [15:0]         r_id;
    logic [4:0]          r_col;
    logic [4:0]          r_row;
    logic [15:0]         r_mag;
    logic                r_neg;
    logic signed [16:0]  r_q [4];

    logic                w_acc;
    logic signed [15:0]  w_org;
    logic signed [16:0]  w_diff;
    logic signed [16:0]  w_diff_neg;
    logic [15:0]         w_mag;
    logic [32:0]         w_prod;
    logic [15:0]         w_quo;
    logic signed [16:0]  w_qu;
    logic signed [16:0]  w_qs;
    logic                w_off;
    logic                w_inverted;
    logic                w_rd_off;
    ugbb_pkg::t_job      w_job;

    assign o_in_ready = (r_state == F_IDLE) && i_init_done;
    assign w_acc      = i_in_valid && o_in_ready;

    // Stage A: offset from origin, split into sign and magnitude.
    assign w_org      = r_k[0] ? i_origin_y : i_origin_x;
    assign w_diff     = 17'(r_coord[r_k[1:0]]) - 17'(w_org);
    assign w_diff_neg = -w_diff;
    assign w_mag      = w_diff[16] ? w_diff_neg[15:0] : w_diff[15:0];

    // Stage B: reciprocal multiply, sign restored (truncation toward zero).
    assign w_prod = 33'(r_mag) * 33'(DIV_M);
    assign w_quo  = 16'(w_prod >> DIV_S);
    assign w_qu   = signed'({1'b0, w_quo});
    assign w_qs   = r_neg ? -w_qu : w_qu;

    assign w_off      = r_q[0][16] || r_q[1][16] || (r_q[2] >= COLS_S) || (r_q[3] >= ROWS_S);
    assign w_inverted = (r_q[0] > r_q[2]) || (r_q[1] > r_q[3]);
    assign w_rd_off   = (9'(r_col) >= 9'(GRID_COLS)) || (9'(r_row) >= 9'(GRID_ROWS));

    always_comb begin
        w_job    = '0;
        w_job.id = r_id;
        unique case (r_cmd)
            ugbb_pkg::CMD_CLEAR: begin
                w_job.kind   = ugbb_pkg::JOB_CLEAR;
                w_job.status = ugbb_pkg::ST_OK;
            end
            ugbb_pkg::CMD_READ: begin
                if (w_rd_off) begin
                    w_job.kind   = ugbb_pkg::JOB_STATUS;
                    w_job.status = ugbb_pkg::ST_OFF_GRID;
                end else begin
                    w_job.kind = ugbb_pkg::JOB_READ;
                    w_job.x0   = ugbb_pkg::IDX_W'(r_col);
                    w_job.y0   = ugbb_pkg::IDX_W'(r_row);
                end
            end
            ugbb_pkg::CMD_ADD, ugbb_pkg::CMD_CHECK: begin
                if (w_off) begin
                    w_job.kind   = ugbb_pkg::JOB_STATUS;
                    w_job.status = ugbb_pkg::ST_OFF_GRID;
                end else if (r_cmd == ugbb_pkg::CMD_CHECK || w_inverted) begin
                    w_job.kind   = ugbb_pkg::JOB_STATUS;
                    w_job.status = ugbb_pkg::ST_OK;
                end else begin
                    w_job.kind = ugbb_pkg::JOB_ADD;
                    w_job.x0   = ugbb_pkg::IDX_W'(r_q[0]);
                    w_job.y0   = ugbb_pkg::IDX_W'(r_q[1]);
                    w_job.x1   = ugbb_pkg::IDX_W'(r_q[2]);
                    w_job.y1   = ugbb_pkg::IDX_W'(r_q[3]);
                end
            end
        endcase
    end

    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_job  = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (w_acc) begin
                        r_cmd      <= ugbb_pkg::t_cmd'(i_cmd);
                        r_coord[0] <= i_box_min_x;
                        r_coord[1] <= i_box_min_y;
                        r_coord[2] <= i_box_max_x;
                        r_coord[3] <= i_box_max_y;
                        r_id       <= i_entity_id;
                        r_col      <= i_cell_col;
                        r_row      <= i_cell_row;
                        r_k        <= '0;
                        if (i_cmd == ugbb_pkg::CMD_ADD || i_cmd == ugbb_pkg::CMD_CHECK) begin
                            r_state <= F_DIV;
                        end else begin
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_DIV: begin
                    if (r_k != K_LAST) begin
                        r_mag <= w_mag;
                        r_neg <= w_diff[16];
                    end
                    if (r_k != '0) begin
                        r_q[2'(r_k - 3'd1)] <= w_qs;
                    end
                    if (r_k == K_LAST) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/ugbb_back.sv =====
// ----------------------------------------------------------------------------
// ugbb_back
// Grid engine: walks covered cells for add, sweeps the valid store for
// clear and after reset, streams a cell's slots for read.
// ----------------------------------------------------------------------------
module ugbb_back #(
    parameter int GRID_COLS      = 32,
    parameter int GRID_ROWS      = 32,
    parameter int SLOTS_PER_CELL = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  ugbb_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_init_done,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_status,
    output logic           o_slot_used,
    output logic [15:0]    o_slot_id,
    output logic           o_last
);

    localparam int NCELLS   = GRID_COLS * GRID_ROWS;
    localparam int CELL_W   = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int SLOT_W   = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
    localparam int ID_DEPTH = (NCELLS > 1) ? (NCELLS << SLOT_W) : (2 << SLOT_W);
    localparam int ROWS_W   = $clog2(GRID_ROWS + 1);
    localparam int MUL_W    = ugbb_pkg::IDX_W + ROWS_W;
    localparam int IDX_W    = ugbb_pkg::IDX_W;

    typedef enum logic [3:0] {
        B_CLR,
        B_IDLE,
        B_ADD_SET,
        B_ADD_RD,
        B_ADD_CHK,
        B_RD_SET,
        B_RD_MASK,
        B_RD_MCAP,
        B_RD_ID,
        B_RD_OUT,
        B_RESP
    } t_bstate;

    t_bstate                   r_state;
    logic                      r_init_done;
    logic                      r_clr_resp;
    logic [CELL_W-1:0]         r_clr_addr;
    ugbb_pkg::t_job            r_job;
    logic [CELL_W-1:0]         r_col_base;
    logic [CELL_W-1:0]         r_cell;
    logic [IDX_W-1:0]          r_x;
    logic [IDX_W-1:0]          r_y;
    logic [SLOT_W-1:0]         r_i;
    logic [SLOTS_PER_CELL-1:0] r_mask;
    logic [1:0]                r_status;

    logic                      r_out_valid;
    logic [1:0]                r_out_status;
    logic                      r_out_used;
    logic [15:0]               r_out_id;
    logic                      r_out_last;

    logic                      w_out_free;
    logic                      w_load_resp;
    logic                      w_load_rd;
    logic                      w_rd_last;
    logic [MUL_W-1:0]          w_col_base0;
    logic [SLOTS_PER_CELL-1:0] w_vrdata;
    logic [SLOTS_PER_CELL-1:0] w_free;
    logic [SLOTS_PER_CELL-1:0] w_onehot;
    logic [SLOT_W-1:0]         w_slot;
    logic                      w_place;
    logic                      w_vwe;
    logic [CELL_W-1:0]         w_vwaddr;
    logic [SLOTS_PER_CELL-1:0] w_vwdata;
    logic [15:0]               w_irdata;

    assign o_pop       = (r_state == B_IDLE) && !i_empty;
    assign o_init_done = r_init_done;

    assign w_col_base0 = MUL_W'(i_job.x0) * MUL_W'(GRID_ROWS);

    // Lowest free slot of the cell just read.
    assign w_free   = ~w_vrdata;
    assign w_onehot = w_free & (~w_free + 1'b1);
    assign w_place  = (r_state == B_ADD_CHK) && (w_free != '0);

    always_comb begin
        w_slot = '0;
        for (int s = SLOTS_PER_CELL - 1; s >= 0; s--) begin
            if (w_free[s]) begin
                w_slot = SLOT_W'(s);
            end
        end
    end

    assign w_vwe    = (r_state == B_CLR) || w_place;
    assign w_vwaddr = (r_state == B_CLR) ? r_clr_addr : r_cell;
    assign w_vwdata = (r_state == B_CLR) ? '0 : (w_vrdata | w_onehot);

    ugbb_ram #(
        .WIDTH (SLOTS_PER_CELL),
        .DEPTH (NCELLS)
    ) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (w_vwaddr),
        .i_wdata (w_vwdata),
        .i_raddr (r_cell),
        .o_rdata (w_vrdata)
    );

    ugbb_ram #(
        .WIDTH (16),
        .DEPTH (ID_DEPTH)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (w_place),
        .i_waddr ({r_cell, w_slot}),
        .i_wdata (r_job.id),
        .i_raddr ({r_cell, r_i}),
        .o_rdata (w_irdata)
    );

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_load_resp = (r_state == B_RESP) && w_out_free;
    assign w_load_rd   = (r_state == B_RD_OUT) && w_out_free;
    assign w_rd_last   = (r_i == SLOT_W'(SLOTS_PER_CELL - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLR;
            r_init_done <= 1'b0;
            r_clr_resp  <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_resp) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_status;
                r_out_used   <= 1'b0;
                r_out_id     <= '0;
                r_out_last   <= 1'b1;
            end else if (w_load_rd) begin
                r_out_valid  <= 1'b1;
                r_out_status <= ugbb_pkg::ST_OK;
                r_out_used   <= r_mask[r_i];
                r_out_id     <= r_mask[r_i] ? w_irdata : '0;
                r_out_last   <= w_rd_last;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                B_CLR: begin
                    if (r_clr_addr == CELL_W'(NCELLS - 1)) begin
                        r_init_done <= 1'b1;
                        r_clr_addr  <= '0;
                        r_status    <= ugbb_pkg::ST_OK;
                        r_state     <= r_clr_resp ? B_RESP : B_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job      <= i_job;
                        r_status   <= i_job.status;
                        r_col_base <= CELL_W'(w_col_base0);
                        unique case (i_job.kind)
                            ugbb_pkg::JOB_STATUS: r_state <= B_RESP;
                            ugbb_pkg::JOB_ADD:    r_state <= B_ADD_SET;
                            ugbb_pkg::JOB_READ:   r_state <= B_RD_SET;
                            ugbb_pkg::JOB_CLEAR: begin
                                r_clr_resp <= 1'b1;
                                r_state    <= B_CLR;
                            end
                        endcase
                    end
                end
                B_ADD_SET: begin
                    r_cell  <= r_col_base + CELL_W'(r_job.y0);
                    r_x     <= r_job.x0;
                    r_y     <= r_job.y0;
                    r_state <= B_ADD_RD;
                end
                B_ADD_RD: begin
                    r_state <= B_ADD_CHK;
                end
                B_ADD_CHK: begin
                    // columns outer, rows inner; a full cell ends the walk
                    if (!w_place) begin
                        r_status <= ugbb_pkg::ST_OVERFLOW;
                        r_state  <= B_RESP;
                    end else if (r_y == r_job.y1) begin
                        if (r_x == r_job.x1) begin
                            r_status <= ugbb_pkg::ST_OK;
                            r_state  <= B_RESP;
                        end else begin
                            r_x        <= r_x + 1'b1;
                            r_y        <= r_job.y0;
                            r_col_base <= r_col_base + CELL_W'(GRID_ROWS);
                            r_cell     <= r_col_base + CELL_W'(GRID_ROWS) + CELL_W'(r_job.y0);
                            r_state    <= B_ADD_RD;
                        end
                    end else begin
                        r_y     <= r_y + 1'b1;
                        r_cell  <= r_cell + 1'b1;
                        r_state <= B_ADD_RD;
                    end
                end
                B_RD_SET: begin
                    r_cell  <= r_col_base + CELL_W'(r_job.y0);
                    r_i     <= '0;
                    r_state <= B_RD_MASK;
                end
                B_RD_MASK: begin
                    r_state <= B_RD_MCAP;
                end
                B_RD_MCAP: begin
                    r_mask  <= w_vrdata;
                    r_state <= B_RD_OUT;
                end
                B_RD_ID: begin
                    r_state <= B_RD_OUT;
                end
                B_RD_OUT: begin
                    if (w_out_free) begin
                        if (w_rd_last) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= B_RD_ID;
                        end
                    end
                end
                B_RESP: begin
                    if (w_out_free) begin
                        r_clr_resp <= 1'b0;
                        r_state    <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_slot_used = r_out_used;
    assign o_slot_id   = r_out_id;
    assign o_last      = r_out_last;

    a_pop_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_init_done)
        else $error("job taken before the valid store was cleared");

    a_one_slot_per_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_place |-> ($countones(w_vwdata) == $countones(w_vrdata) + 1))
        else $error("add must claim exactly one new slot");

    a_walk_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_ADD_CHK) |-> (r_x >= r_job.x0 && r_x <= r_job.x1 &&
                                    r_y >= r_job.y0 && r_y <= r_job.y1))
        else $error("cell walk left the box");

    a_read_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_rd && w_rd_last) |=> (r_state == B_IDLE && r_out_last))
        else $error("read run did not close with last");

endmodule

// ===== sv/uniform_grid_box_binner.sv =====
// ----------------------------------------------------------------------------
// uniform_grid_box_binner
// Broadphase grid: adds boxes to the cells they cover, checks range,
// clears the grid and reads out one cell's slots.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_ready    | i_cmd, box corners, i_entity_id,
//         |           |                            | i_cell_col, i_cell_row
// out     | output    | o_out_valid / i_out_ready  | o_status, o_slot_used, o_slot_id, o_last
// cfg     | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_wdata
//
// Classifier: clear/read go straight to the push state; add/check first pass the four
// corners through one reciprocal multiplier. Engine: add walks the covered cells, read
// streams one result per slot, clear sweeps the valid store, status-only jobs respond.
// After reset the engine sweeps all GRID_COLS*GRID_ROWS cells of the valid store
// (1024 by default); o_in_ready stays low until it is done.
// A two-entry job queue lets the classifier take the next command while the
// engine works; a held result stalls the engine, and the classifier once the queue is full.
// ----------------------------------------------------------------------------
module uniform_grid_box_binner #(
    parameter int GRID_COLS      = 32,
    parameter int GRID_ROWS      = 32,
    parameter int CELL_SIZE      = 32,
    parameter int SLOTS_PER_CELL = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [15:0] i_box_min_x,
    input  logic signed [15:0] i_box_min_y,
    input  logic signed [15:0] i_box_max_x,
    input  logic signed [15:0] i_box_max_y,
    input  logic [15:0]        i_entity_id,
    input  logic [4:0]         i_cell_col,
    input  logic [4:0]         i_cell_row,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic               o_slot_used,
    output logic [15:0]        o_slot_id,
    output logic               o_last
);

    logic signed [15:0] r_origin_x;
    logic signed [15:0] r_origin_y;

    logic               w_init_done;
    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_empty;
    ugbb_pkg::t_job     w_push_job;
    ugbb_pkg::t_job     w_head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= ugbb_pkg::ORIGIN_RESET;
            r_origin_y <= ugbb_pkg::ORIGIN_RESET;
        end else if (i_cfg_we) begin
            unique case (ugbb_pkg::t_cfg_reg'(i_cfg_idx))
                ugbb_pkg::CFG_ORIGIN_X: r_origin_x <= signed'(i_cfg_wdata);
                ugbb_pkg::CFG_ORIGIN_Y: r_origin_y <= signed'(i_cfg_wdata);
            endcase
        end
    end

    ugbb_front #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS),
        .CELL_SIZE (CELL_SIZE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_origin_x  (r_origin_x),
        .i_origin_y  (r_origin_y),
        .i_init_done (w_init_done),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_box_min_x (i_box_min_x),
        .i_box_min_y (i_box_min_y),
        .i_box_max_x (i_box_max_x),
        .i_box_max_y (i_box_max_y),
        .i_entity_id (i_entity_id),
        .i_cell_col  (i_cell_col),
        .i_cell_row  (i_cell_row),
        .o_push      (w_push),
        .o_job       (w_push_job),
        .i_full      (w_full)
    );

    ugbb_fifo #(
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_empty)
    );

    ugbb_back #(
        .GRID_COLS      (GRID_COLS),
        .GRID_ROWS      (GRID_ROWS),
        .SLOTS_PER_CELL (SLOTS_PER_CELL)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_init_done (w_init_done),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_slot_used (o_slot_used),
        .o_slot_id   (o_slot_id),
        .o_last      (o_last)
    );

endmodule

// ===== dv/uniform_grid_box_binner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_box_binner_tb
// Drives add/check/clear/read commands into the grid binner through
// random sender and receiver idling. Every result is checked against a cycle-free grid
// model kept with the stimulus, or a fixed directed row's status. A directed table comes
// first, then random phases under several grid origins, extremes included.
// ----------------------------------------------------------------------------
module uniform_grid_box_binner_tb;

    localparam int GRID_COLS      = 32;
    localparam int GRID_ROWS      = 32;
    localparam int CELL_SIZE      = 32;
    localparam int SLOTS_PER_CELL = 4;
    localparam int STORE_DEPTH    = GRID_COLS * GRID_ROWS * SLOTS_PER_CELL;
    localparam int N_PHASES       = 7;
    localparam int PHASE_ITEMS    = 36;
    // Longest quiet stretch is a full-grid add or a clear.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 50;

    typedef struct {
        ugbb_pkg::t_cmd     cmd;
        logic signed [15:0] min_x;
        logic signed [15:0] min_y;
        logic signed [15:0] max_x;
        logic signed [15:0] max_y;
        logic [15:0]        id;
        logic [4:0]         col;
        logic [4:0]         row;
    } t_box_req;

    typedef struct {
        logic [1:0]  status;
        logic        used;
        logic [15:0] id;
        logic        last;
    } t_slot_rsp;

    typedef struct {
        t_box_req   req;
        bit         fixed;
        logic [1:0] fix_st;
    } t_dir_row;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_idx   = ugbb_pkg::CFG_ORIGIN_X;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd       = ugbb_pkg::CMD_CHECK;
    logic signed [15:0] box_min_x = '0;
    logic signed [15:0] box_min_y = '0;
    logic signed [15:0] box_max_x = '0;
    logic signed [15:0] box_max_y = '0;
    logic [15:0] entity_id = '0;
    logic [4:0]  cell_col  = '0;
    logic [4:0]  cell_row  = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic        slot_used;
    logic [15:0] slot_id;
    logic        last;

    // grid model
    logic signed [15:0] grid_origin_x = ugbb_pkg::ORIGIN_RESET;
    logic signed [15:0] grid_origin_y = ugbb_pkg::ORIGIN_RESET;
    logic [15:0]        grid_id   [STORE_DEPTH];
    bit                 grid_used [STORE_DEPTH];

    t_slot_rsp pending_rsp [$];
    t_dir_row  dir_rows [$];
    t_slot_rsp want;

    bit no_idle = 1'b0;
    int n_err = 0, n_in = 0, n_rsp = 0, n_ovf = 0, n_off = 0, n_cfg = 0;
    int quiet_cycles = 0;

    int phase_ox [N_PHASES] = '{0, -32768, 32767, -32768, 32767, 0, -512};
    int phase_oy [N_PHASES] = '{0, -32768, 32767, 32767, -32768, 0, -512};

    uniform_grid_box_binner #(
        .GRID_COLS      (GRID_COLS),
        .GRID_ROWS      (GRID_ROWS),
        .CELL_SIZE      (CELL_SIZE),
        .SLOTS_PER_CELL (SLOTS_PER_CELL)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_cmd       (cmd),
        .i_box_min_x (box_min_x),
        .i_box_min_y (box_min_y),
        .i_box_max_x (box_max_x),
        .i_box_max_y (box_max_y),
        .i_entity_id (entity_id),
        .i_cell_col  (cell_col),
        .i_cell_row  (cell_row),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_status    (status),
        .o_slot_used (slot_used),
        .o_slot_id   (slot_id),
        .o_last      (last)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // (coord - origin) / CELL_SIZE, truncated toward zero
    function automatic int cell_of(logic signed [15:0] coord, logic signed [15:0] origin);
        return (int'(coord) - int'(origin)) / CELL_SIZE;
    endfunction

    function automatic void predict_grid_rsp(input t_box_req r, ref t_slot_rsp rsp[$]);
        int sx, sy, ex, ey, base, x, y, k;
        logic [1:0] st;
        bit placed;
        rsp.delete();
        st = ugbb_pkg::ST_OK;
        case (r.cmd)
            ugbb_pkg::CMD_CLEAR: begin
                for (k = 0; k < STORE_DEPTH; k++) grid_used[k] = 1'b0;
                rsp.push_back('{ugbb_pkg::ST_OK, 1'b0, 16'h0, 1'b1});
            end
            ugbb_pkg::CMD_READ: begin
                if (int'(r.col) >= GRID_COLS || int'(r.row) >= GRID_ROWS) begin
                    rsp.push_back('{ugbb_pkg::ST_OFF_GRID, 1'b0, 16'h0, 1'b1});
                end else begin
                    base = (int'(r.col) * GRID_ROWS + int'(r.row)) * SLOTS_PER_CELL;
                    for (k = 0; k < SLOTS_PER_CELL; k++) begin
                        rsp.push_back('{ugbb_pkg::ST_OK, grid_used[base+k],
                                        grid_used[base+k] ? grid_id[base+k] : 16'h0,
                                        k == SLOTS_PER_CELL - 1});
                    end
                end
            end
            default: begin
                sx = cell_of(r.min_x, grid_origin_x);
                sy = cell_of(r.min_y, grid_origin_y);
                ex = cell_of(r.max_x, grid_origin_x);
                ey = cell_of(r.max_y, grid_origin_y);
                if (sx < 0 || sy < 0 || ex >= GRID_COLS || ey >= GRID_ROWS) begin
                    rsp.push_back('{ugbb_pkg::ST_OFF_GRID, 1'b0, 16'h0, 1'b1});
                end else begin
                    // columns outer, rows inner; a full cell ends the walk
                    if (r.cmd == ugbb_pkg::CMD_ADD) begin
                        for (x = sx; x <= ex && st == ugbb_pkg::ST_OK; x++) begin
                            for (y = sy; y <= ey && st == ugbb_pkg::ST_OK; y++) begin
                                base = (x * GRID_ROWS + y) * SLOTS_PER_CELL;
                                placed = 1'b0;
                                for (k = 0; k < SLOTS_PER_CELL && !placed; k++) begin
                                    if (!grid_used[base+k]) begin
                                        grid_used[base+k] = 1'b1;
                                        grid_id[base+k]   = r.id;
                                        placed = 1'b1;
                                    end
                                end
                                if (!placed) st = ugbb_pkg::ST_OVERFLOW;
                            end
                        end
                    end
                    rsp.push_back('{st, 1'b0, 16'h0, 1'b1});
                end
            end
        endcase
    endfunction

    function automatic void dir_row(ugbb_pkg::t_cmd c, int mnx, int mny, int mxx, int mxy,
                                    int id, int col, int row, bit fixed, logic [1:0] st);
        t_dir_row d;
        d.req = '{c, mnx[15:0], mny[15:0], mxx[15:0], mxy[15:0], id[15:0],
                  col[4:0], row[4:0]};
        d.fixed  = fixed;
        d.fix_st = st;
        dir_rows.push_back(d);
    endfunction

    // world coordinate inside cell c of the current origin, saturated to 16 bits
    function automatic logic signed [15:0] place(logic signed [15:0] origin, int c);
        int v;
        v = int'(origin) + c * CELL_SIZE + $urandom_range(0, CELL_SIZE - 1);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic send(input t_box_req r, input bit fixed, input logic [1:0] fix_st);
        int gap, k, n;
        t_slot_rsp rsp [$];
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        cmd       <= r.cmd;
        box_min_x <= r.min_x;
        box_min_y <= r.min_y;
        box_max_x <= r.max_x;
        box_max_y <= r.max_y;
        entity_id <= r.id;
        cell_col  <= r.col;
        cell_row  <= r.row;
        do @(posedge clk); while (!in_ready);
        n_in++;
        predict_grid_rsp(r, rsp);
        if (fixed) begin
            n = rsp.size();
            rsp.delete();
            for (k = 0; k < n; k++) rsp.push_back('{fix_st, 1'b0, 16'h0, k == n - 1});
        end
        foreach (rsp[k]) pending_rsp.push_back(rsp[k]);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    task automatic set_origin(input logic signed [15:0] ox, input logic signed [15:0] oy);
        drain();
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= ugbb_pkg::CFG_ORIGIN_X;
        cfg_wdata <= ox;
        @(negedge clk);
        cfg_idx   <= ugbb_pkg::CFG_ORIGIN_Y;
        cfg_wdata <= oy;
        @(negedge clk);
        cfg_we    <= 1'b0;
        grid_origin_x = ox;
        grid_origin_y = oy;
        n_cfg++;
    endtask

    // receiver: random stall before each result
    initial begin
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            repeat (stall) begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_rsp.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result: status=%0d used=%0d id=%h last=%0d",
                             status, slot_used, slot_id, last);
            end else begin
                want = pending_rsp.pop_front();
                n_rsp++;
                if (want.status == ugbb_pkg::ST_OVERFLOW) n_ovf++;
                if (want.status == ugbb_pkg::ST_OFF_GRID) n_off++;
                if (status !== want.status || slot_used !== want.used ||
                    slot_id !== want.id || last !== want.last) begin
                    n_err++;
                    if (n_err <= 10)
                        $display({"mismatch @%0t: exp st=%0d used=%0d id=%h last=%0d,",
                                  " got st=%0d used=%0d id=%h last=%0d"},
                                 $time, want.status, want.used, want.id, want.last,
                                 status, slot_used, slot_id, last);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                     quiet_cycles, pending_rsp.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_box_req r;
        int p, k, pick, sx, sy, ex, ey, t;
        logic signed [15:0] ox, oy;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // origin -512: cell c spans -512+32c .. -481+32c on both axes
        // empty after reset
        dir_row(ugbb_pkg::CMD_READ, 0, 0, 0, 0, 'h0000, 0, 0, 1, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_READ, 0, 0, 0, 0, 'h0000, 31, 31, 1, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_ADD, -512, -512, -512, -512, 'hFFFF, 0, 0, 0, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_ADD, -500, -490, -481, -481, 'h0000, 0, 0, 0, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_READ, 0, 0, 0, 0, 'h0000, 0, 0, 0, ugbb_pkg::ST_OK);
        // whole grid
        dir_row(ugbb_pkg::CMD_ADD, -512, -512, 511, 511, 'h1234, 0, 0, 0, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_ADD, -512, -512, -512, -512, 'hA5A5, 0, 0, 0, ugbb_pkg::ST_OK);
        // cell full
        dir_row(ugbb_pkg::CMD_ADD, -512, -512, -512, -512, 'h5A5A, 0, 0, 0, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_READ, 0, 0, 0, 0, 'h0000, 0, 0, 0, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_ADD, -512, -512, 512, 0, 'h1111, 0, 0, 1,
                ugbb_pkg::ST_OFF_GRID);
        dir_row(ugbb_pkg::CMD_ADD, -512, -512, 0, 512, 'h2222, 0, 0, 1,
                ugbb_pkg::ST_OFF_GRID);
        // truncates to col 0
        dir_row(ugbb_pkg::CMD_ADD, -543, 0, -540, 10, 'h0F0F, 0, 0, 0, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_ADD, -544, 0, -540, 10, 'hF0F0, 0, 0, 1,
                ugbb_pkg::ST_OFF_GRID);
        dir_row(ugbb_pkg::CMD_ADD, -32768, -32768, 32767, 32767, 'hFFFF, 0, 0, 1,
                ugbb_pkg::ST_OFF_GRID);
        dir_row(ugbb_pkg::CMD_CHECK, 32767, 32767, 32767, 32767, 'h0000, 0, 0, 1,
                ugbb_pkg::ST_OFF_GRID);
        dir_row(ugbb_pkg::CMD_CHECK, -512, -512, 511, 511, 'h0000, 0, 0, 1, ugbb_pkg::ST_OK);
        // inverted in x
        dir_row(ugbb_pkg::CMD_ADD, 100, 0, 0, 100, 'h7777, 0, 0, 0, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_READ, 0, 0, 0, 0, 'h0000, 19, 16, 0, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_ADD, -416, -352, -416, -352, 'h0301, 0, 0, 0, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_ADD, -416, -352, -416, -352, 'h0302, 0, 0, 0, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_ADD, -416, -352, -416, -352, 'h0303, 0, 0, 0, ugbb_pkg::ST_OK);
        // stops mid-walk
        dir_row(ugbb_pkg::CMD_ADD, -448, -352, -416, -352, 'h0BAD, 0, 0, 0, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_READ, 0, 0, 0, 0, 'h0000, 2, 5, 0, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_CLEAR, 0, 0, 0, 0, 'h0000, 0, 0, 1, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_READ, 0, 0, 0, 0, 'h0000, 0, 0, 1, ugbb_pkg::ST_OK);
        dir_row(ugbb_pkg::CMD_READ, 0, 0, 0, 0, 'h0000, 3, 5, 1, ugbb_pkg::ST_OK);

        foreach (dir_rows[k]) send(dir_rows[k].req, dir_rows[k].fixed, dir_rows[k].fix_st);

        for (p = 0; p < N_PHASES; p++) begin
            ox = phase_ox[p][15:0];
            oy = phase_oy[p][15:0];
            if (p == 5) begin
                ox = 16'($urandom());
                oy = 16'($urandom());
            end
            set_origin(ox, oy);
            no_idle = (p == 2);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                pick  = $urandom_range(0, 99);
                r.cmd = ugbb_pkg::CMD_ADD;
                r.min_x = 16'($urandom());
                r.min_y = 16'($urandom());
                r.max_x = 16'($urandom());
                r.max_y = 16'($urandom());
                r.id    = 16'($urandom_range(0, 65535));
                r.col   = 5'($urandom());
                r.row   = 5'($urandom());
                if (pick < 60) begin
                    // boxes crowd the low corner so cells fill up and overflow
                    r.cmd = (pick < 50) ? ugbb_pkg::CMD_ADD : ugbb_pkg::CMD_CHECK;
                    sx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                     : $urandom_range(0, 31);
                    sy = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                     : $urandom_range(0, 31);
                    ex = sx + (($urandom_range(0, 24) == 0) ? $urandom_range(0, 31)
                                                            : $urandom_range(0, 2));
                    ey = sy + (($urandom_range(0, 24) == 0) ? $urandom_range(0, 31)
                                                            : $urandom_range(0, 2));
                    if ($urandom_range(0, 19) == 0) sx = -1;
                    if ($urandom_range(0, 19) == 0) sy = -1;
                    if ($urandom_range(0, 14) == 0) begin
                        t  = sx;
                        sx = ex;
                        ex = t;
                    end
                    r.min_x = place(grid_origin_x, sx);
                    r.min_y = place(grid_origin_y, sy);
                    r.max_x = place(grid_origin_x, ex);
                    r.max_y = place(grid_origin_y, ey);
                end else if (pick < 63) begin
                    r.cmd = ugbb_pkg::CMD_CLEAR;
                end else if (pick < 83) begin
                    r.cmd = ugbb_pkg::CMD_READ;
                    if ($urandom_range(0, 9) < 7) begin
                        r.col = 5'($urandom_range(0, 3));
                        r.row = 5'($urandom_range(0, 3));
                    end
                end else begin
                    case ($urandom_range(0, 2))
                        0:       r.cmd = ugbb_pkg::CMD_ADD;
                        1:       r.cmd = ugbb_pkg::CMD_CHECK;
                        default: r.cmd = ugbb_pkg::CMD_READ;
                    endcase
                end
                send(r, 1'b0, ugbb_pkg::ST_OK);
                if ($urandom_range(0, 39) == 0) drain();
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_rsp.size() != 0) begin
            n_err += pending_rsp.size();
            $display("%0d expected results never arrived", pending_rsp.size());
        end
        $display("%0d commands under %0d origin settings (range extremes included)",
                 n_in, n_cfg + 1);
        $display("%0d results checked, %0d overflow and %0d off-grid statuses, %0d errors",
                 n_rsp, n_ovf, n_off, n_err);
        if (n_err == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
